// ----- design/bbce_pkg.sv -----
// Shared types, request codes and register indexes for the clamped-edge box blur.
// No dependencies; imported by the blur top level and the testbench.
`default_nettype none

package bbce_pkg;

  typedef logic [7:0] chan_t;

  // One RGB pixel as it is held in the line store.
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  // Request kinds.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RADIUS       = 2'd2;

  localparam int unsigned CFG_DATA_W = 13;

endpackage

`default_nettype wire

// ----- design/bbce_mod.sv -----
// Multi-cycle unit that forms (a * b) mod MODULUS by reciprocal multiplication.
// Stand-alone; used by the blur top level to find line store row bases.
`default_nettype none

module bbce_mod #(
  parameter int unsigned A_W     = 13,
  parameter int unsigned B_W     = 12,
  parameter int unsigned MODULUS = 30720,
  parameter int unsigned RES_W   = $clog2(MODULUS)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [A_W-1:0]   a_i,
  input  wire logic [B_W-1:0]   b_i,
  output logic                  busy_o,
  output logic [RES_W-1:0]      res_o
);

  localparam int unsigned P_W   = A_W + B_W;
  localparam int unsigned CNT_W = 2;
  localparam logic [RES_W:0]   MOD_L = (RES_W + 1)'(MODULUS);
  localparam logic [P_W-1:0]   MOD_P = P_W'(MODULUS);
  // Reciprocal scaled by 2^P_W; the quotient estimate is at most one too small.
  localparam logic [P_W-1:0]   RECIP = P_W'((64'd1 << P_W) / 64'(MODULUS));

  localparam logic [CNT_W-1:0] ST_QUOT = 2'd3;
  localparam logic [CNT_W-1:0] ST_REM  = 2'd2;
  localparam logic [CNT_W-1:0] ST_FIX  = 2'd1;

  logic [P_W-1:0]   prod_q, prod_d;
  logic [P_W-1:0]   quo_q, quo_d;
  logic [RES_W:0]   rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [2*P_W-1:0] wide;

  // Product, quotient estimate, remainder, then one correcting subtraction.
  always_comb begin
    prod_d = prod_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    wide   = (2 * P_W)'(prod_q) * (2 * P_W)'(RECIP);
    if (start_i) begin
      prod_d = P_W'(a_i) * P_W'(b_i);
      cnt_d  = ST_QUOT;
      busy_d = 1'b1;
    end else if (busy_q) begin
      case (cnt_q)
        ST_QUOT: begin
          quo_d = wide[2*P_W-1:P_W];
        end
        ST_REM: begin
          rem_d = (RES_W + 1)'(prod_q - P_W'(quo_q * MOD_P));
        end
        ST_FIX: begin
          if (rem_q >= MOD_L) begin
            rem_d = rem_q - MOD_L;
          end
          busy_d = 1'b0;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
  end

  assign busy_o = busy_q;
  assign res_o  = rem_q[RES_W-1:0];

endmodule

`default_nettype wire

// ----- design/box_blur_clamped_edges.sv -----
// Box blur with clamp-to-edge borders over an RGB raster stream.
// Depends on bbce_pkg and bbce_mod.
//
// Usage: pixels of one frame enter in raster order on the input channel
// (op_i low); a request with op_i high is a drain tick that carries no pixel
// and lets held-back results out once the frame has ended. Each request gives
// at most one result on the output channel: the mean of the window of side
// 2*radius+1 around the oldest pending pixel, with frame_last_o marking the
// final pixel of the frame. Frame size and radius are set through the write
// port; the user must do so only while the block is idle, which is not enforced.
// Timing: one request is handled at a time. When no result is due, a request
// goes through the row base calculation in bbce_mod, then the store and the
// return to idle. When a result is due, the window is read after the row base
// calculation, one line store read per window pixel through the single read
// port, and the sums go through the bit-serial divider over the accumulator
// width (16 bits at the default radius limit) before the result and the store.
// The result sits in an output register; while the receiver stalls, the next
// request is still taken and worked on until its own result is ready.
// Reset clears all counters and restores width 640, height 480, radius 1.
// The line store is not cleared; it holds defined data wherever it is read.
`default_nettype none

module box_blur_clamped_edges
  import bbce_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned MAX_RADIUS = 7
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  op_i,
  input  wire logic [7:0]            in_red_i,
  input  wire logic [7:0]            in_green_i,
  input  wire logic [7:0]            in_blue_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [7:0]                 out_red_o,
  output logic [7:0]                 out_green_o,
  output logic [7:0]                 out_blue_o,
  output logic                       frame_last_o
);

  localparam int unsigned COL_W    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ROW_W    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned R_W      = $clog2(MAX_RADIUS + 2);
  localparam int unsigned IX_W     = $clog2(2 * MAX_RADIUS + 2);
  localparam int unsigned DEPTH    = MAX_WIDTH * (2 * MAX_RADIUS + 1);
  localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned MW       = $clog2(DEPTH);
  localparam int unsigned AREA_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int unsigned AREA_W   = $clog2(AREA_MAX + 1);
  localparam int unsigned ACC_W    = $clog2(AREA_MAX * 255 + 1);
  localparam int unsigned DCNT_W   = $clog2(ACC_W + 1);
  localparam int unsigned XS_W     = COL_W + R_W + 2;
  localparam int unsigned YS_W     = ROW_W + R_W + 2;
  localparam logic [AW:0] DEPTH_L  = (AW + 1)'(DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;
  localparam logic [2:0] S_STORE = 3'd6;

  // Sum of a ring address and an offset below the ring depth, wrapped once.
  function automatic logic [AW-1:0] add_ring(input logic [AW-1:0] base,
                                             input logic [COL_W-1:0] offs);
    logic [AW:0] sum;
    sum = (AW + 1)'(base) + (AW + 1)'(offs);
    if (sum >= DEPTH_L) begin
      sum = sum - DEPTH_L;
    end
    return AW'(sum);
  endfunction

  // Configuration registers.
  logic [11:0] image_width_q;
  logic [12:0] image_height_q;
  logic [2:0]  radius_q;

  // Stream position state.
  logic [COL_W-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic             frame_rx_q, frame_rx_d;

  // Request state.
  logic [2:0]        state_q, state_d;
  logic              op_q;
  rgb_t              pix_q;
  logic              emit_q, emit_d;
  logic              ended_q, ended_d;
  logic [AREA_W-1:0] area_q;

  // Window sweep.
  logic [IX_W-1:0]  ix_q, ix_d, iy_q, iy_d;
  logic [AW-1:0]    base_q, base_d;
  logic [ROW_W-1:0] ycl_q, ycl_d;

  // Line store and read pipeline.
  rgb_t             mem [DEPTH];
  rgb_t             rdata_q;
  logic             rvalid_q;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             mem_we;
  logic [AW-1:0]    wr_addr;

  // Accumulate then divide, per channel.
  logic [ACC_W-1:0]  acc_q [3];
  logic [ACC_W-1:0]  acc_d [3];
  logic [AREA_W-1:0] rem_q [3];
  logic [AREA_W-1:0] rem_d [3];
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;
  logic [7:0]        rd_chan [3];

  // Output register.
  logic        out_valid_q, out_valid_d;
  rgb_t        out_pix_q;
  logic        out_last_q;
  logic        out_load;

  // Effective register values and derived positions.
  logic [COL_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [R_W-1:0]   r_eff;
  logic [ROW_W:0]   ny;
  logic [COL_W:0]   nx;
  logic             ready_now;
  logic             in_wrap;
  logic [COL_W-1:0] c_n;
  logic [ROW_W-1:0] rw_n;
  logic signed [YS_W-1:0] ys0, ysn;
  logic signed [XS_W-1:0] xs;
  logic [ROW_W-1:0] y0, ycl_next;
  logic [COL_W-1:0] xcl;
  logic             accept;
  logic [MW-1:0]    out_base, in_base;
  logic             out_mod_busy, in_mod_busy;

  // Registers clamped to their usable ranges.
  always_comb begin
    if (image_width_q == '0) begin
      w_eff = COL_W'(1);
    end else if (32'(image_width_q) > MAX_WIDTH) begin
      w_eff = COL_W'(MAX_WIDTH);
    end else begin
      w_eff = COL_W'(image_width_q);
    end
    if (image_height_q == '0) begin
      h_eff = ROW_W'(1);
    end else if (32'(image_height_q) > MAX_HEIGHT) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = ROW_W'(image_height_q);
    end
    if (32'(radius_q) > MAX_RADIUS) begin
      r_eff = R_W'(MAX_RADIUS);
    end else begin
      r_eff = R_W'(radius_q);
    end
  end

  // Whether the oldest pending output has all of its window stored.
  always_comb begin
    ny = (ROW_W + 1)'(out_row_q) + (ROW_W + 1)'(r_eff);
    if (ny > (ROW_W + 1)'(h_eff - 1'b1)) begin
      ny = (ROW_W + 1)'(h_eff - 1'b1);
    end
    nx = (COL_W + 1)'(out_col_q) + (COL_W + 1)'(r_eff);
    if (nx > (COL_W + 1)'(w_eff - 1'b1)) begin
      nx = (COL_W + 1)'(w_eff - 1'b1);
    end
    ready_now = frame_rx_q || (ny < (ROW_W + 1)'(in_row_q)) ||
                ((ny == (ROW_W + 1)'(in_row_q)) && (nx < (COL_W + 1)'(in_col_q)));
  end

  // Input position after wrapping a column left over from a narrower frame.
  always_comb begin
    in_wrap = (in_col_q >= w_eff);
    c_n     = in_wrap ? '0 : in_col_q;
    rw_n    = in_wrap ? ROW_W'(in_row_q + 1'b1) : in_row_q;
  end

  // Window row and column positions, clamped to the frame.
  always_comb begin
    ys0 = YS_W'(out_row_q) - YS_W'(r_eff);
    if (ys0[YS_W-1]) begin
      y0 = '0;
    end else if (ys0 > YS_W'(h_eff - 1'b1)) begin
      y0 = h_eff - 1'b1;
    end else begin
      y0 = ROW_W'(ys0);
    end
    ysn = YS_W'(out_row_q) - YS_W'(r_eff) + YS_W'(iy_q) + YS_W'(1);
    if (ysn[YS_W-1]) begin
      ycl_next = '0;
    end else if (ysn > YS_W'(h_eff - 1'b1)) begin
      ycl_next = h_eff - 1'b1;
    end else begin
      ycl_next = ROW_W'(ysn);
    end
    xs = XS_W'(out_col_q) - XS_W'(r_eff) + XS_W'(ix_q);
    if (xs[XS_W-1]) begin
      xcl = '0;
    end else if (xs > XS_W'(w_eff - 1'b1)) begin
      xcl = w_eff - 1'b1;
    end else begin
      xcl = COL_W'(xs);
    end
  end

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  // Row bases in the ring: first window row, and the row being written.
  bbce_mod #(
    .A_W     (ROW_W),
    .B_W     (COL_W),
    .MODULUS (DEPTH)
  ) u_out_base (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .a_i     (y0),
    .b_i     (w_eff),
    .busy_o  (out_mod_busy),
    .res_o   (out_base)
  );

  bbce_mod #(
    .A_W     (ROW_W),
    .B_W     (COL_W),
    .MODULUS (DEPTH)
  ) u_in_base (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .a_i     (rw_n),
    .b_i     (w_eff),
    .busy_o  (in_mod_busy),
    .res_o   (in_base)
  );

  assign rd_chan[0] = rdata_q.red;
  assign rd_chan[1] = rdata_q.green;
  assign rd_chan[2] = rdata_q.blue;

  // Request sequencer: when a result is due, read the window, divide and emit; then store the pixel, if any.
  always_comb begin
    logic [COL_W:0]   nc;
    logic [ROW_W:0]   nr;
    logic [COL_W-1:0] c;
    logic [ROW_W:0]   rw;
    logic [AW:0]      wsum;
    logic [AREA_W:0]  shifted;

    state_d     = state_q;
    emit_d      = emit_q;
    ended_d     = ended_q;
    ix_d        = ix_q;
    iy_d        = iy_q;
    base_d      = base_q;
    ycl_d       = ycl_q;
    dcnt_d      = dcnt_q;
    in_col_d    = in_col_q;
    in_row_d    = in_row_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    frame_rx_d  = frame_rx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_load    = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = add_ring(base_q, xcl);
    mem_we      = 1'b0;
    nc          = '0;
    nr          = '0;
    c           = '0;
    rw          = '0;
    wsum        = '0;
    shifted     = '0;
    for (int k = 0; k < 3; k++) begin
      acc_d[k] = acc_q[k];
      rem_d[k] = rem_q[k];
    end
    if (rvalid_q) begin
      for (int k = 0; k < 3; k++) begin
        acc_d[k] = acc_q[k] + ACC_W'(rd_chan[k]);
      end
    end

    // Store address for the pending pixel.
    c      = c_n;
    wsum   = (AW + 1)'(ended_q ? '0 : in_base) + (AW + 1)'(c);
    if (wsum >= DEPTH_L) begin
      wsum = wsum - DEPTH_L;
    end
    wr_addr = AW'(wsum);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          emit_d  = ready_now;
          ended_d = 1'b0;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (!out_mod_busy && !in_mod_busy) begin
          if (emit_q) begin
            ix_d    = '0;
            iy_d    = '0;
            base_d  = AW'(out_base);
            ycl_d   = y0;
            for (int k = 0; k < 3; k++) begin
              acc_d[k] = '0;
            end
            state_d = S_SWEEP;
          end else begin
            state_d = S_STORE;
          end
        end
      end
      S_SWEEP: begin
        rd_en = 1'b1;
        if (ix_q == IX_W'(2 * r_eff)) begin
          ix_d = '0;
          if (iy_q == IX_W'(2 * r_eff)) begin
            state_d = S_FLUSH;
          end else begin
            iy_d = iy_q + 1'b1;
            if (ycl_next != ycl_q) begin
              base_d = add_ring(base_q, w_eff);
              ycl_d  = ycl_next;
            end
          end
        end else begin
          ix_d = ix_q + 1'b1;
        end
      end
      S_FLUSH: begin
        for (int k = 0; k < 3; k++) begin
          rem_d[k] = '0;
        end
        dcnt_d  = DCNT_W'(ACC_W);
        state_d = S_DIV;
      end
      S_DIV: begin
        for (int k = 0; k < 3; k++) begin
          shifted = {rem_q[k], acc_q[k][ACC_W-1]};
          if (shifted >= (AREA_W + 1)'(area_q)) begin
            rem_d[k] = AREA_W'(shifted - (AREA_W + 1)'(area_q));
            acc_d[k] = {acc_q[k][ACC_W-2:0], 1'b1};
          end else begin
            rem_d[k] = AREA_W'(shifted);
            acc_d[k] = {acc_q[k][ACC_W-2:0], 1'b0};
          end
        end
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == DCNT_W'(1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          nc = (COL_W + 1)'(out_col_q) + 1'b1;
          nr = (ROW_W + 1)'(out_row_q);
          if (nc >= (COL_W + 1)'(w_eff)) begin
            nc = '0;
            nr = nr + 1'b1;
          end
          if (nr >= (ROW_W + 1)'(h_eff)) begin
            ended_d    = 1'b1;
            in_col_d   = '0;
            in_row_d   = '0;
            out_col_d  = '0;
            out_row_d  = '0;
            frame_rx_d = 1'b0;
          end else begin
            out_col_d = COL_W'(nc);
            out_row_d = ROW_W'(nr);
          end
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        if (op_q == OP_PIXEL && !frame_rx_q) begin
          rw = (ROW_W + 1)'(rw_n);
          if (rw < (ROW_W + 1)'(h_eff)) begin
            mem_we = 1'b1;
            if ((COL_W + 1)'(c) + 1'b1 >= (COL_W + 1)'(w_eff)) begin
              c  = '0;
              rw = rw + 1'b1;
            end else begin
              c = c + 1'b1;
            end
          end
          if (rw >= (ROW_W + 1)'(h_eff)) begin
            frame_rx_d = 1'b1;
            in_col_d   = '0;
            in_row_d   = '0;
          end else begin
            in_col_d = c;
            in_row_d = ROW_W'(rw);
          end
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      image_width_q  <= 12'd640;
      image_height_q <= 13'd480;
      radius_q       <= 3'd1;
      in_col_q       <= '0;
      in_row_q       <= '0;
      out_col_q      <= '0;
      out_row_q      <= '0;
      frame_rx_q     <= 1'b0;
      emit_q         <= 1'b0;
      ended_q        <= 1'b0;
      ix_q           <= '0;
      iy_q           <= '0;
      dcnt_q         <= '0;
      rvalid_q       <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      frame_rx_q  <= frame_rx_d;
      emit_q      <= emit_d;
      ended_q     <= ended_d;
      ix_q        <= ix_d;
      iy_q        <= iy_d;
      dcnt_q      <= dcnt_d;
      rvalid_q    <= rd_en;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata_i[11:0];
          CFG_IMAGE_HEIGHT: image_height_q <= cfg_wdata_i;
          CFG_RADIUS:       radius_q       <= cfg_wdata_i[2:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_i;
      pix_q  <= '{red: in_red_i, green: in_green_i, blue: in_blue_i};
      area_q <= AREA_W'((2 * r_eff + 1) * (2 * r_eff + 1));
    end
    base_q <= base_d;
    ycl_q  <= ycl_d;
    for (int k = 0; k < 3; k++) begin
      acc_q[k] <= acc_d[k];
      rem_q[k] <= rem_d[k];
    end
    if (out_load) begin
      out_pix_q  <= '{red: acc_q[0][7:0], green: acc_q[1][7:0], blue: acc_q[2][7:0]};
      out_last_q <= ended_d;
    end
  end

  // Line store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= pix_q;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_red_o    = out_pix_q.red;
  assign out_green_o  = out_pix_q.green;
  assign out_blue_o   = out_pix_q.blue;
  assign frame_last_o = out_last_q;

  // The line store is never read and written in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(rd_en && mem_we))
    else $error("line store read and write overlap");

  // A request is only taken while both row base units are idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (!out_mod_busy && !in_mod_busy))
    else $error("request taken while base calculation busy");

  // Once the whole frame is stored the input position rests at the origin.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_rx_q |-> (in_col_q == '0 && in_row_q == '0))
    else $error("input position not cleared at frame end");

  // A waiting result is never overwritten by the sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !out_load)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for box_blur_clamped_edges: a directed table, then
// random frames, checked against an in-bench blur predictor. Depends on bbce_pkg.
`timescale 1ns / 100ps

module tb;
  import bbce_pkg::*;

  localparam int unsigned MAXW = 2048;
  localparam int unsigned MAXH = 4096;
  localparam int unsigned MAXR = 7;
  localparam int unsigned RING = MAXW * (2 * MAXR + 1);
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned SETTLE = 300;
  localparam int unsigned RAND_ITEMS = 1900;

  typedef struct {
    rgb_t px;
    logic last;
  } blur_res_t;

  // Kinds of directed row.
  typedef enum logic [1:0] {ROW_CFG, ROW_PRED, ROW_NONE, ROW_RES} row_kind_e;

  typedef struct {
    row_kind_e kind;
    logic [1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    logic op;
    rgb_t px;
    logic last;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic op_i = OP_PIXEL;
  logic [7:0] in_red_i = '0, in_green_i = '0, in_blue_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] out_red_o, out_green_o, out_blue_o;
  logic frame_last_o;

  box_blur_clamped_edges uut (.*);

  // Predictor state.
  rgb_t blur_store [RING];
  int unsigned rx_col, rx_row, tx_col, tx_row;
  bit frame_full;
  int unsigned reg_w, reg_h, reg_r;

  blur_res_t blur_q[$];
  int unsigned fails = 0;
  int unsigned req_count = 0;
  bit calm = 1'b0;
  int unsigned quiet_cycles = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned width_used();
    return (reg_w < 1) ? 1 : ((reg_w > MAXW) ? MAXW : reg_w);
  endfunction

  function automatic int unsigned height_used();
    return (reg_h < 1) ? 1 : ((reg_h > MAXH) ? MAXH : reg_h);
  endfunction

  function automatic bit at_frame_start();
    return !frame_full && rx_col == 0 && rx_row == 0 && tx_col == 0 && tx_row == 0;
  endfunction

  // Advances the predictor by one request; returns 1 when a result is due.
  function automatic bit blur_step(input logic op, input rgb_t px, output blur_res_t res);
    int unsigned w, h, r, ny, nx, sr, sg, sb, area, c, rw;
    int yy, xx;
    bit due;
    w = width_used();
    h = height_used();
    r = (reg_r > MAXR) ? MAXR : reg_r;
    res = '{px: '0, last: 1'b0};
    if (frame_full) begin
      due = 1'b1;
    end else begin
      ny = (tx_row + r > h - 1) ? h - 1 : tx_row + r;
      nx = (tx_col + r > w - 1) ? w - 1 : tx_col + r;
      due = (ny < rx_row) || (ny == rx_row && nx < rx_col);
    end
    if (due) begin
      sr = 0; sg = 0; sb = 0;
      for (int dy = -int'(r); dy <= int'(r); dy++) begin
        yy = int'(tx_row) + dy;
        yy = (yy < 0) ? 0 : ((yy > int'(h) - 1) ? int'(h) - 1 : yy);
        for (int dx = -int'(r); dx <= int'(r); dx++) begin
          rgb_t p;
          xx = int'(tx_col) + dx;
          xx = (xx < 0) ? 0 : ((xx > int'(w) - 1) ? int'(w) - 1 : xx);
          p = blur_store[(yy * w + xx) % RING];
          sr += p.red; sg += p.green; sb += p.blue;
        end
      end
      area = (2 * r + 1) * (2 * r + 1);
      res.px = '{red: 8'(sr / area), green: 8'(sg / area), blue: 8'(sb / area)};
      c = tx_col + 1;
      rw = tx_row;
      if (c >= w) begin
        c = 0; rw++;
      end
      if (rw >= h) begin
        res.last = 1'b1;
        rx_col = 0; rx_row = 0; tx_col = 0; tx_row = 0;
        frame_full = 1'b0;
      end else begin
        tx_col = c; tx_row = rw;
      end
    end
    // A pixel is stored unless the frame is already complete.
    if (op == OP_PIXEL && !frame_full) begin
      c = rx_col;
      rw = rx_row;
      if (c >= w) begin
        c = 0; rw++;
      end
      if (rw < h) begin
        blur_store[(rw * w + c) % RING] = px;
        c++;
        if (c >= w) begin
          c = 0; rw++;
        end
      end
      if (rw >= h) begin
        frame_full = 1'b1; rx_col = 0; rx_row = 0;
      end else begin
        rx_col = c; rx_row = rw;
      end
    end
    return due;
  endfunction

  // Presents one request and waits for it to be taken.
  task automatic send_req(input logic op, input rgb_t px, input row_kind_e kind = ROW_PRED,
                          input blur_res_t typed = '{px: '0, last: 1'b0});
    blur_res_t res;
    bit due;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    op_i = op;
    {in_red_i, in_green_i, in_blue_i} = px;
    do @(posedge clk_i); while (!in_ready_o);
    due = blur_step(op, px, res);
    if (kind == ROW_RES) blur_q.push_back(typed);
    else if (kind == ROW_PRED && due) blur_q.push_back(res);
    req_count++;
  endtask

  // Holds the sender until every result is out and the block has settled.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (blur_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    case (idx)
      CFG_IMAGE_WIDTH:  reg_w = data & 13'hFFF;
      CFG_IMAGE_HEIGHT: reg_h = data;
      default:          reg_r = data & 13'h7;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic rgb_t rand_px();
    rgb_t p;
    p = rgb_t'(24'($urandom));
    if ($urandom_range(0, 9) == 0) p.red = 8'hFF;
    if ($urandom_range(0, 9) == 0) p.blue = 8'h00;
    return p;
  endfunction

  // One whole frame of random pixels with random drain ticks mixed in, then drains until the frame closes.
  task automatic run_frame();
    int unsigned total;
    total = width_used() * height_used();
    for (int unsigned i = 0; i < total; i++) begin
      if ($urandom_range(0, 19) == 0) send_req(OP_DRAIN, rand_px());
      send_req(OP_PIXEL, rand_px());
    end
    while (!at_frame_start()) begin
      // A stray pixel is sent only where it is sure to be dropped.
      if (frame_full && $urandom_range(0, 6) == 0 &&
          total - (tx_row * width_used() + tx_col) > 1)
        send_req(OP_PIXEL, rand_px());
      else
        send_req(OP_DRAIN, rand_px());
    end
  endtask

  // Randomly stalls the receiver in short bursts.
  initial begin
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // Result checker against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (blur_q.size() == 0) begin
        $error("unexpected result %h %h %h last %b", out_red_o, out_green_o, out_blue_o,
               frame_last_o);
        fails++;
      end else begin
        blur_res_t e;
        e = blur_q.pop_front();
        if (out_red_o !== e.px.red) begin
          $error("out_red: expected %0d, got %0d", e.px.red, out_red_o); fails++;
        end
        if (out_green_o !== e.px.green) begin
          $error("out_green: expected %0d, got %0d", e.px.green, out_green_o); fails++;
        end
        if (out_blue_o !== e.px.blue) begin
          $error("out_blue: expected %0d, got %0d", e.px.blue, out_blue_o); fails++;
        end
        if (frame_last_o !== e.last) begin
          $error("frame_last: expected %0d, got %0d", e.last, frame_last_o); fails++;
        end
      end
    end
  end

  // Watchdog on cycles with no request moving on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  row_t rows[$];

  initial begin
    blur_res_t typed;
    for (int unsigned i = 0; i < RING; i++) blur_store[i] = '0;
    rx_col = 0; rx_row = 0; tx_col = 0; tx_row = 0;
    frame_full = 1'b0;
    reg_w = 640; reg_h = 480; reg_r = 1;

    // Directed table: single-pixel frames read straight off, then a 3x2 frame.
    rows = '{
      '{ROW_CFG, CFG_IMAGE_WIDTH, 13'd1, OP_PIXEL, '0, 1'b0},
      '{ROW_CFG, CFG_IMAGE_HEIGHT, 13'd1, OP_PIXEL, '0, 1'b0},
      '{ROW_CFG, CFG_RADIUS, 13'd0, OP_PIXEL, '0, 1'b0},
      '{ROW_NONE, 2'd0, 13'd0, OP_PIXEL, '{8'd255, 8'd0, 8'd128}, 1'b0},
      '{ROW_RES, 2'd0, 13'd0, OP_DRAIN, '{8'd255, 8'd0, 8'd128}, 1'b1},
      '{ROW_NONE, 2'd0, 13'd0, OP_PIXEL, '{8'd0, 8'd255, 8'd1}, 1'b0},
      // Frame end and a new first pixel in the same request.
      '{ROW_RES, 2'd0, 13'd0, OP_PIXEL, '{8'd0, 8'd255, 8'd1}, 1'b1},
      '{ROW_RES, 2'd0, 13'd0, OP_DRAIN, '{8'd0, 8'd255, 8'd1}, 1'b1},
      // Nothing waiting: a drain gives no result.
      '{ROW_NONE, 2'd0, 13'd0, OP_DRAIN, '0, 1'b0},
      '{ROW_CFG, CFG_RADIUS, 13'd7, OP_PIXEL, '0, 1'b0},
      '{ROW_NONE, 2'd0, 13'd0, OP_PIXEL, '{8'd170, 8'd85, 8'd240}, 1'b0},
      '{ROW_RES, 2'd0, 13'd0, OP_DRAIN, '{8'd170, 8'd85, 8'd240}, 1'b1},
      '{ROW_CFG, CFG_IMAGE_WIDTH, 13'd3, OP_PIXEL, '0, 1'b0},
      '{ROW_CFG, CFG_IMAGE_HEIGHT, 13'd2, OP_PIXEL, '0, 1'b0},
      '{ROW_CFG, CFG_RADIUS, 13'd1, OP_PIXEL, '0, 1'b0},
      '{ROW_PRED, 2'd0, 13'd0, OP_PIXEL, '{8'd255, 8'd255, 8'd255}, 1'b0},
      '{ROW_PRED, 2'd0, 13'd0, OP_PIXEL, '{8'd0, 8'd0, 8'd0}, 1'b0},
      '{ROW_PRED, 2'd0, 13'd0, OP_PIXEL, '{8'd17, 8'd200, 8'd3}, 1'b0},
      '{ROW_PRED, 2'd0, 13'd0, OP_PIXEL, '{8'd128, 8'd64, 8'd32}, 1'b0},
      '{ROW_PRED, 2'd0, 13'd0, OP_PIXEL, '{8'd1, 8'd254, 8'd127}, 1'b0},
      '{ROW_PRED, 2'd0, 13'd0, OP_PIXEL, '{8'd90, 8'd9, 8'd250}, 1'b0},
      // Stray pixel while the frame is complete: dropped.
      '{ROW_PRED, 2'd0, 13'd0, OP_PIXEL, '{8'd77, 8'd77, 8'd77}, 1'b0},
      '{ROW_PRED, 2'd0, 13'd0, OP_DRAIN, '0, 1'b0},
      '{ROW_PRED, 2'd0, 13'd0, OP_DRAIN, '0, 1'b0},
      '{ROW_PRED, 2'd0, 13'd0, OP_DRAIN, '0, 1'b0},
      '{ROW_PRED, 2'd0, 13'd0, OP_DRAIN, '0, 1'b0}
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        typed = '{px: rows[i].px, last: rows[i].last};
        send_req(rows[i].op, rows[i].px, rows[i].kind, typed);
      end
    end
    while (!at_frame_start()) send_req(OP_DRAIN, '0);

    // Random small frames, with zero and masked sizes; the final stretch runs
    // without idling.
    while (req_count < RAND_ITEMS) begin
      int unsigned w, h;
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      write_reg(CFG_IMAGE_WIDTH, {1'($urandom), 12'(w)});
      write_reg(CFG_IMAGE_HEIGHT, 13'(h));
      write_reg(CFG_RADIUS, {10'($urandom), 3'($urandom_range(0, MAXR))});
      if (req_count > RAND_ITEMS - 250) calm = 1'b1;
      run_frame();
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (blur_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/bbce_pkg.sv
design/bbce_mod.sv
design/box_blur_clamped_edges.sv
sim/tb.sv
